FILE: rtl/ats_pkg.sv
`timescale 1ns / 1ps
package ats_pkg;

   localparam int ENTRIES  = 64;
   localparam int IDX_W    = 6;
   localparam int CNT_W    = 7;
   localparam int WEIGHT_W = 32;
   localparam int RES_W    = 38;
   localparam int AMT_W    = 33;
   localparam int FRAC_W   = 32;

   localparam logic [1:0] MODE_SET  = 2'd0;
   localparam logic [1:0] MODE_ADD  = 2'd1;
   localparam logic [1:0] MODE_DRAW = 2'd2;

   localparam logic [CNT_W-1:0] N_RESET = CNT_W'(ENTRIES);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPD,
      ST_SUM,
      ST_INIT,
      ST_P_CHK,
      ST_P_LQ,
      ST_P_LR,
      ST_P_SQ,
      ST_P_SR,
      ST_P_UPD,
      ST_DRAW0,
      ST_DRAW1,
      ST_DRAW2
   } state_type;

   typedef struct packed {
      logic             res_we;
      logic [IDX_W-1:0] res_addr;
      logic [RES_W-1:0] res_data;
      logic             ali_we;
      logic [IDX_W-1:0] ali_addr;
      logic [IDX_W-1:0] ali_data;
   } tbl_wr_type;

endpackage

FILE: rtl/ats_queue_mem.sv
`timescale 1ns / 1ps
module ats_queue_mem
   import ats_pkg::*;
(
   input  logic             clock,
   input  logic             we,
   input  logic [IDX_W-1:0] waddr,
   input  logic [IDX_W-1:0] wdata,
   input  logic             re,
   input  logic [IDX_W-1:0] raddr,
   output logic [IDX_W-1:0] rdata
);

   logic [IDX_W-1:0] mem [ENTRIES];
   logic [IDX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/ats_table_mem.sv
`timescale 1ns / 1ps
module ats_table_mem
   import ats_pkg::*;
(
   input  logic             clock,
   input  tbl_wr_type       wr,
   input  logic             re,
   input  logic [IDX_W-1:0] raddr,
   output logic [RES_W-1:0] res_rdata,
   output logic [IDX_W-1:0] ali_rdata
);

   logic [RES_W-1:0] res_mem [ENTRIES];
   logic [IDX_W-1:0] ali_mem [ENTRIES];
   logic [RES_W-1:0] res_rdata_ff;
   logic [IDX_W-1:0] ali_rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.res_we) begin
         res_mem[wr.res_addr] <= wr.res_data;
      end
      if (wr.ali_we) begin
         ali_mem[wr.ali_addr] <= wr.ali_data;
      end
      if (re) begin
         res_rdata_ff <= res_mem[raddr];
         ali_rdata_ff <= ali_mem[raddr];
      end
   end

   assign res_rdata = res_rdata_ff;
   assign ali_rdata = ali_rdata_ff;

endmodule

FILE: rtl/alias_table_sampler.sv
`timescale 1ns / 1ps
// Weighted index sampler, alias method, 64 entries of 32-bit weights.
// req_ channel: one word per item; mode 0 sets a weight, mode 1 adds a
// signed change (clamped to 0..2^32-1), mode 2 draws an index from
// rand_slot and rand_frac, mode 3 does nothing. Every word gives one rsp_
// word; sample_index, is_draw and empty_total are zero for non-draw words.
// csr_ port: csr_write loads entries_in_use (0 acts as 1, above 64 as 64);
// the block then sums the active weights, stalling req_.
// An update word goes through ST_UPD and a draw through ST_DRAW0 to ST_DRAW2
// before the registered result; a new word is taken only in ST_IDLE, once the
// word before it is done, no-ops every cycle; a zero total ends at ST_DRAW0.
// A draw after any update rebuilds the table first if the total is nonzero:
// ST_INIT scales weights by n and fills the work queues; a pairing step reads
// its small entry (ST_P_SQ, ST_P_SR) unless just released, a new large entry
// via ST_P_LQ, ST_P_LR, all through the residual memory's single read port.
// Reset clears all weights (per-entry valid bits), the total and the
// queues, marks the table stale and sets entries_in_use to 64.
// While rsp_stall holds a result, the block takes no new req_ word.
module alias_table_sampler
   import ats_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_mode,
   input  logic [IDX_W-1:0]        req_entry_index,
   input  logic signed [AMT_W-1:0] req_amount,
   input  logic [IDX_W-1:0]        req_rand_slot,
   input  logic [FRAC_W-1:0]       req_rand_frac,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [IDX_W-1:0]        rsp_sample_index,
   output logic                    rsp_is_draw,
   output logic                    rsp_empty_total,
   input  logic                    csr_write,
   input  logic [CNT_W-1:0]        csr_wdata
);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [RES_W-1:0] total_ff, total_in;
   logic stale_ff, stale_in, sum_pend_ff, sum_pend_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic pv_ff, pv_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic [CNT_W-1:0] s_head_ff, s_head_in, s_tail_ff, s_tail_in;
   logic [CNT_W-1:0] l_head_ff, l_head_in, l_tail_ff, l_tail_in;
   logic lg_valid_ff, lg_valid_in, held_ff, held_in;
   logic [IDX_W-1:0] lg_id_ff, lg_id_in, held_id_ff, held_id_in, sm_id_ff, sm_id_in;
   logic [RES_W-1:0] lg_res_ff, lg_res_in, held_res_ff, held_res_in, sm_res_ff, sm_res_in;
   logic [1:0] op_mode_ff, op_mode_in;
   logic [IDX_W-1:0] op_idx_ff, op_idx_in, slot_ff, slot_in;
   logic signed [AMT_W-1:0] op_amt_ff, op_amt_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [63:0] p_lo_ff, p_lo_in;
   logic [RES_W-1:0] p_hi_ff, p_hi_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic rsp_draw_ff, rsp_draw_in, rsp_empty_ff, rsp_empty_in;

   // weight memory with per-entry valid bits
   logic [WEIGHT_W-1:0] wmem [ENTRIES];
   logic [ENTRIES-1:0] wvalid_ff;
   logic [WEIGHT_W-1:0] wrdata_ff;
   logic wrok_ff;
   logic w_re, w_we;
   logic [IDX_W-1:0] w_raddr, w_waddr;
   logic [WEIGHT_W-1:0] w_wdata;

   tbl_wr_type tbl_wr;
   logic tbl_re;
   logic [IDX_W-1:0] tbl_raddr;
   logic [RES_W-1:0] res_rdata;
   logic [IDX_W-1:0] ali_rdata;

   logic sq_we, lq_we, sq_re, lq_re;
   logic [IDX_W-1:0] sq_waddr, lq_waddr, q_wdata, sq_raddr, lq_raddr, sq_rdata, lq_rdata;

   logic req_acc;
   logic [WEIGHT_W-1:0] w_cur;
   logic [38:0] prod;
   logic [RES_W-1:0] res_new;
   logic [38:0] pair_sum;
   logic signed [AMT_W:0] add_sum;
   logic [WEIGHT_W-1:0] nw;
   logic [RES_W-1:0] b_val;
   logic s_ne, l_ne;

   ats_table_mem u_table (
      .clock     (clock),
      .wr        (tbl_wr),
      .re        (tbl_re),
      .raddr     (tbl_raddr),
      .res_rdata (res_rdata),
      .ali_rdata (ali_rdata)
   );

   ats_queue_mem u_small_q (
      .clock (clock),
      .we    (sq_we),
      .waddr (sq_waddr),
      .wdata (q_wdata),
      .re    (sq_re),
      .raddr (sq_raddr),
      .rdata (sq_rdata)
   );

   ats_queue_mem u_large_q (
      .clock (clock),
      .we    (lq_we),
      .waddr (lq_waddr),
      .wdata (q_wdata),
      .re    (lq_re),
      .raddr (lq_raddr),
      .rdata (lq_rdata)
   );

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_waddr] <= w_wdata;
      end
      if (w_re) begin
         wrdata_ff <= wmem[w_raddr];
      end
   end

   assign req_stall = !(state_ff == ST_IDLE && !sum_pend_ff && !csr_write &&
                        (!rsp_valid_ff || !rsp_stall));
   assign req_acc = req_valid && !req_stall;
   assign w_cur = wrok_ff ? wrdata_ff : '0;
   assign prod = {7'b0, w_cur} * {32'b0, n_ff};
   assign pair_sum = {1'b0, lg_res_ff} + {1'b0, sm_res_ff} - {1'b0, total_ff};
   assign add_sum = $signed({2'b0, w_cur}) + $signed({op_amt_ff[AMT_W-1], op_amt_ff});
   assign b_val = p_hi_ff + {6'b0, p_lo_ff[63:32]};
   assign s_ne = held_ff || (s_head_ff < s_tail_ff);
   assign l_ne = lg_valid_ff || (l_head_ff < l_tail_ff);

   always_comb begin
      state_in = state_ff;   n_in = n_ff;         total_in = total_ff;
      stale_in = stale_ff;   sum_pend_in = sum_pend_ff;
      cnt_in = cnt_ff;       pv_in = pv_ff;       pidx_in = pidx_ff;
      s_head_in = s_head_ff; s_tail_in = s_tail_ff;
      l_head_in = l_head_ff; l_tail_in = l_tail_ff;
      lg_valid_in = lg_valid_ff; lg_id_in = lg_id_ff; lg_res_in = lg_res_ff;
      held_in = held_ff;     held_id_in = held_id_ff; held_res_in = held_res_ff;
      sm_id_in = sm_id_ff;   sm_res_in = sm_res_ff;
      op_mode_in = op_mode_ff; op_idx_in = op_idx_ff; op_amt_in = op_amt_ff;
      slot_in = slot_ff;     frac_in = frac_ff;
      p_lo_in = p_lo_ff;     p_hi_in = p_hi_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff; rsp_draw_in = rsp_draw_ff; rsp_empty_in = rsp_empty_ff;
      w_re = 1'b0; w_raddr = '0; w_we = 1'b0; w_waddr = op_idx_ff; w_wdata = '0;
      tbl_wr = '0; tbl_re = 1'b0; tbl_raddr = '0;
      sq_we = 1'b0; lq_we = 1'b0; sq_waddr = s_tail_ff[IDX_W-1:0];
      lq_waddr = l_tail_ff[IDX_W-1:0]; q_wdata = pidx_ff;
      sq_re = 1'b0; lq_re = 1'b0;
      sq_raddr = s_head_ff[IDX_W-1:0]; lq_raddr = l_head_ff[IDX_W-1:0];
      nw = '0; res_new = '0;

      case (state_ff)
         ST_IDLE: begin
            if (sum_pend_ff) begin
               sum_pend_in = 1'b0;
               cnt_in = '0;
               pv_in = 1'b0;
               total_in = '0;
               state_in = ST_SUM;
            end else if (req_acc) begin
               op_mode_in = req_mode;
               op_idx_in = req_entry_index;
               op_amt_in = req_amount;
               frac_in = req_rand_frac;
               slot_in = ({1'b0, req_rand_slot} >= n_ff) ? IDX_W'(n_ff - 1'b1)
                                                         : req_rand_slot;
               case (req_mode)
                  MODE_SET, MODE_ADD: begin
                     w_re = 1'b1;
                     w_raddr = req_entry_index;
                     state_in = ST_UPD;
                  end
                  MODE_DRAW: begin
                     if (stale_ff && total_ff != '0) begin
                        cnt_in = '0;
                        pv_in = 1'b0;
                        s_tail_in = '0;
                        l_tail_in = '0;
                        state_in = ST_INIT;
                     end else begin
                        stale_in = 1'b0;
                        state_in = ST_DRAW0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_index_in = '0;
                     rsp_draw_in = 1'b0;
                     rsp_empty_in = 1'b0;
                  end
               endcase
            end
         end
         ST_UPD: begin
            if (op_mode_ff == MODE_SET) begin
               nw = op_amt_ff[AMT_W-1] ? '0 : op_amt_ff[WEIGHT_W-1:0];
            end else if (add_sum[AMT_W]) begin
               nw = '0;
            end else if (add_sum[WEIGHT_W]) begin
               nw = '1;
            end else begin
               nw = add_sum[WEIGHT_W-1:0];
            end
            w_we = 1'b1;
            w_wdata = nw;
            if ({1'b0, op_idx_ff} < n_ff) begin
               total_in = total_ff - {6'b0, w_cur} + {6'b0, nw};
            end
            stale_in = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_index_in = '0;
            rsp_draw_in = 1'b0;
            rsp_empty_in = 1'b0;
            state_in = ST_IDLE;
         end
         ST_SUM: begin
            pv_in = 1'b0;
            if (cnt_ff < n_ff) begin
               w_re = 1'b1;
               w_raddr = cnt_ff[IDX_W-1:0];
               cnt_in = cnt_ff + 1'b1;
               pv_in = 1'b1;
            end
            if (pv_ff) begin
               total_in = total_ff + {6'b0, w_cur};
            end
            if (cnt_ff == n_ff && !pv_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_INIT: begin
            pv_in = 1'b0;
            if (cnt_ff < n_ff) begin
               w_re = 1'b1;
               w_raddr = cnt_ff[IDX_W-1:0];
               pidx_in = cnt_ff[IDX_W-1:0];
               cnt_in = cnt_ff + 1'b1;
               pv_in = 1'b1;
            end
            if (pv_ff) begin
               tbl_wr.res_we = 1'b1;
               tbl_wr.res_addr = pidx_ff;
               tbl_wr.res_data = prod[RES_W-1:0];
               tbl_wr.ali_we = 1'b1;
               tbl_wr.ali_addr = pidx_ff;
               tbl_wr.ali_data = pidx_ff;
               if (prod[RES_W-1:0] > total_ff) begin
                  lq_we = 1'b1;
                  l_tail_in = l_tail_ff + 1'b1;
               end else if (prod[RES_W-1:0] < total_ff) begin
                  sq_we = 1'b1;
                  s_tail_in = s_tail_ff + 1'b1;
               end
            end
            if (cnt_ff == n_ff && !pv_ff) begin
               s_head_in = '0;
               l_head_in = '0;
               lg_valid_in = 1'b0;
               held_in = 1'b0;
               state_in = ST_P_CHK;
            end
         end
         ST_P_CHK: begin
            if (!(s_ne && l_ne)) begin
               stale_in = 1'b0;
               state_in = ST_DRAW0;
            end else if (!lg_valid_ff) begin
               lq_re = 1'b1;
               l_head_in = l_head_ff + 1'b1;
               state_in = ST_P_LQ;
            end else if (held_ff) begin
               sm_id_in = held_id_ff;
               sm_res_in = held_res_ff;
               held_in = 1'b0;
               state_in = ST_P_UPD;
            end else begin
               sq_re = 1'b1;
               s_head_in = s_head_ff + 1'b1;
               state_in = ST_P_SQ;
            end
         end
         ST_P_LQ: begin
            lg_id_in = lq_rdata;
            tbl_re = 1'b1;
            tbl_raddr = lq_rdata;
            state_in = ST_P_LR;
         end
         ST_P_LR: begin
            lg_res_in = res_rdata;
            lg_valid_in = 1'b1;
            state_in = ST_P_CHK;
         end
         ST_P_SQ: begin
            sm_id_in = sq_rdata;
            tbl_re = 1'b1;
            tbl_raddr = sq_rdata;
            state_in = ST_P_SR;
         end
         ST_P_SR: begin
            sm_res_in = res_rdata;
            state_in = ST_P_UPD;
         end
         ST_P_UPD: begin
            res_new = pair_sum[RES_W-1:0];
            tbl_wr.res_we = 1'b1;
            tbl_wr.res_addr = lg_id_ff;
            tbl_wr.res_data = res_new;
            tbl_wr.ali_we = 1'b1;
            tbl_wr.ali_addr = sm_id_ff;
            tbl_wr.ali_data = lg_id_ff;
            lg_res_in = res_new;
            if (res_new <= total_ff) begin
               lg_valid_in = 1'b0;
               if (res_new < total_ff) begin
                  held_in = 1'b1;
                  held_id_in = lg_id_ff;
                  held_res_in = res_new;
               end
            end
            state_in = ST_P_CHK;
         end
         ST_DRAW0: begin
            if (total_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = slot_ff;
               rsp_draw_in = 1'b1;
               rsp_empty_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               tbl_re = 1'b1;
               tbl_raddr = slot_ff;
               p_lo_in = {32'b0, frac_ff} * {32'b0, total_ff[31:0]};
               state_in = ST_DRAW1;
            end
         end
         ST_DRAW1: begin
            p_hi_in = {6'b0, frac_ff} * {32'b0, total_ff[RES_W-1:32]};
            state_in = ST_DRAW2;
         end
         ST_DRAW2: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = (b_val <= res_rdata) ? slot_ff : ali_rdata;
            rsp_draw_in = 1'b1;
            rsp_empty_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write) begin
         if (csr_wdata == '0) begin
            n_in = CNT_W'(1);
         end else if (csr_wdata > N_RESET) begin
            n_in = N_RESET;
         end else begin
            n_in = csr_wdata;
         end
         stale_in = 1'b1;
         sum_pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff <= N_RESET;
         total_ff <= '0;
         stale_ff <= 1'b1;
         sum_pend_ff <= 1'b0;
         cnt_ff <= '0;
         pv_ff <= 1'b0;
         s_head_ff <= '0;
         s_tail_ff <= '0;
         l_head_ff <= '0;
         l_tail_ff <= '0;
         lg_valid_ff <= 1'b0;
         held_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wvalid_ff <= '0;
         wrok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
         total_ff <= total_in;
         stale_ff <= stale_in;
         sum_pend_ff <= sum_pend_in;
         cnt_ff <= cnt_in;
         pv_ff <= pv_in;
         s_head_ff <= s_head_in;
         s_tail_ff <= s_tail_in;
         l_head_ff <= l_head_in;
         l_tail_ff <= l_tail_in;
         lg_valid_ff <= lg_valid_in;
         held_ff <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         if (w_we) begin
            wvalid_ff[w_waddr] <= 1'b1;
         end
         if (w_re) begin
            wrok_ff <= wvalid_ff[w_raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= pidx_in;
      lg_id_ff <= lg_id_in;
      lg_res_ff <= lg_res_in;
      held_id_ff <= held_id_in;
      held_res_ff <= held_res_in;
      sm_id_ff <= sm_id_in;
      sm_res_ff <= sm_res_in;
      op_mode_ff <= op_mode_in;
      op_idx_ff <= op_idx_in;
      op_amt_ff <= op_amt_in;
      slot_ff <= slot_in;
      frac_ff <= frac_in;
      p_lo_ff <= p_lo_in;
      p_hi_ff <= p_hi_in;
      rsp_index_ff <= rsp_index_in;
      rsp_draw_ff <= rsp_draw_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_index = rsp_index_ff;
   assign rsp_is_draw = rsp_draw_ff;
   assign rsp_empty_total = rsp_empty_ff;

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (state_ff == ST_IDLE))
      else $error("word accepted while busy");

   a_nondraw_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_draw_ff) |-> (rsp_index_ff == '0 && !rsp_empty_ff))
      else $error("non-draw result not zero");

   a_fresh_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW1) |-> !stale_ff)
      else $error("draw on stale table");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (n_ff != '0) && (n_ff <= N_RESET))
      else $error("entry count out of range");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
   import ats_pkg::*;

   localparam logic [1:0] MODE_NOP = 2'd3;
   localparam int LIMIT = 4000000;

   typedef struct {
      bit [IDX_W-1:0] index;
      bit             is_draw;
      bit             empty;
   } sample_word_type;

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    req_valid = 0;
   logic                    req_stall;
   logic [1:0]              req_mode = '0;
   logic [IDX_W-1:0]        req_entry_index = '0;
   logic signed [AMT_W-1:0] req_amount = '0;
   logic [IDX_W-1:0]        req_rand_slot = '0;
   logic [FRAC_W-1:0]       req_rand_frac = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 0;
   logic [IDX_W-1:0]        rsp_sample_index;
   logic                    rsp_is_draw;
   logic                    rsp_empty_total;
   logic                    csr_write = 0;
   logic [CNT_W-1:0]        csr_wdata = '0;

   alias_table_sampler DUT (.*);

   // weight table model
   bit [63:0]      weight_mem [ENTRIES];
   bit [63:0]      residual_mem [ENTRIES];
   int             alias_mem [ENTRIES];
   bit [63:0]      weight_sum;
   bit             table_dirty;
   bit [CNT_W-1:0] entry_count;

   sample_word_type pending_samples [$];
   int             cycle_count = 0;
   int             mismatches = 0;
   int             words_sent = 0;
   int             draws_checked = 0;
   int             send_idle_pct = 0;
   int             stall_pct = 0;
   int             hold_left = 0;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("timeout, %0d words outstanding", pending_samples.size());
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic int active_entries();
      if (entry_count == 0) return 1;
      if (entry_count > ENTRIES) return ENTRIES;
      return entry_count;
   endfunction

   function automatic void refresh_alias_model();
      int        n;
      bit [63:0] cap;
      int        small_q [$];
      int        large_q [$];
      int        lg;
      int        sm;
      n = active_entries();
      cap = weight_sum;
      table_dirty = 0;
      if (cap == 0) return;
      for (int i = 0; i < n; i++) begin
         residual_mem[i] = weight_mem[i] * n;
         alias_mem[i] = i;
         if (residual_mem[i] > cap) large_q.insert(large_q.size(), i);
         else if (residual_mem[i] < cap) small_q.insert(small_q.size(), i);
      end
      while (small_q.size() > 0 && large_q.size() > 0) begin
         lg = large_q[0];
         sm = small_q[0];
         small_q.delete(0);
         residual_mem[lg] -= cap - residual_mem[sm];
         alias_mem[sm] = lg;
         if (residual_mem[lg] > cap) continue;
         large_q.delete(0);
         if (residual_mem[lg] < cap) small_q.insert(0, lg);
      end
   endfunction

   function automatic void load_entry_count(bit [CNT_W-1:0] value);
      entry_count = value;
      weight_sum = 0;
      for (int i = 0; i < active_entries(); i++) weight_sum += weight_mem[i];
      table_dirty = 1;
   endfunction

   function automatic sample_word_type predict_sample(logic [1:0] mode, int index,
         logic signed [AMT_W-1:0] amount, int slot, bit [31:0] frac);
      sample_word_type w;
      longint        v;
      bit [63:0]     b;
      int            n;
      w = '{default: 0};
      n = active_entries();
      if (mode == MODE_SET || mode == MODE_ADD) begin
         v = longint'(amount);
         if (mode == MODE_ADD) v += longint'(weight_mem[index]);
         if (v < 0) v = 0;
         if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
         if (index < n) weight_sum = weight_sum - weight_mem[index] + v;
         weight_mem[index] = v;
         table_dirty = 1;
      end else if (mode == MODE_DRAW) begin
         if (slot >= n) slot = n - 1;
         if (table_dirty) refresh_alias_model();
         w.is_draw = 1;
         if (weight_sum == 0) begin
            w.index = IDX_W'(slot);
            w.empty = 1;
         end else begin
            b = 64'(frac) * (weight_sum >> 32)
                + ((64'(frac) * (weight_sum & 64'hFFFF_FFFF)) >> 32);
            w.index = (b <= residual_mem[slot]) ? IDX_W'(slot) : IDX_W'(alias_mem[slot]);
         end
      end
      return w;
   endfunction

   always @(posedge clock) begin
      sample_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: index %0d draw %0d empty %0d",
               rsp_sample_index, rsp_is_draw, rsp_empty_total);
         end else begin
            e = pending_samples[0];
            pending_samples.delete(0);
            if (e.is_draw) draws_checked++;
            if (rsp_sample_index !== e.index || rsp_is_draw !== e.is_draw ||
                rsp_empty_total !== e.empty) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at cycle %0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
                     cycle_count, e.index, e.is_draw, e.empty,
                     rsp_sample_index, rsp_is_draw, rsp_empty_total);
            end
         end
      end
   end

   task automatic send_word(logic [1:0] mode, int index, logic signed [AMT_W-1:0] amount,
         int slot, bit [31:0] frac);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_entry_index <= IDX_W'(index);
      req_amount <= amount;
      req_rand_slot <= IDX_W'(slot);
      req_rand_frac <= frac;
      do @(posedge clock); while (req_stall);
      pending_samples.insert(pending_samples.size(),
         predict_sample(mode, index, amount, slot, frac));
      words_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_samples.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_entry_count(bit [CNT_W-1:0] value);
      wait_idle();
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      load_entry_count(value);
   endtask

   function automatic logic signed [AMT_W-1:0] pick_amount();
      case ($urandom_range(5))
         0: return AMT_W'($urandom_range(1000));
         1: return {1'b0, 32'hFFFF_FFFF};
         2: return {1'b1, 32'h0000_0001};
         3: return '0;
         default: return {1'($urandom_range(1)), 32'($urandom())};
      endcase
   endfunction

   task automatic test_directed();
      send_word(MODE_DRAW, 0, 0, 63, 32'hFFFF_FFFF);
      send_word(MODE_NOP, 5, 33'sd7, 9, 32'h1234);
      send_word(MODE_SET, 0, {1'b0, 32'hFFFF_FFFF}, 0, 0);
      send_word(MODE_DRAW, 0, 0, 0, 0);
      send_word(MODE_DRAW, 0, 0, 63, 32'hFFFF_FFFF);
      send_word(MODE_SET, 63, 33'sd100, 0, 0);
      send_word(MODE_ADD, 63, {1'b0, 32'hFFFF_FFFF}, 0, 0);
      send_word(MODE_SET, 1, {1'b1, 32'h0000_0001}, 0, 0);
      send_word(MODE_ADD, 0, {1'b1, 32'h0000_0001}, 0, 0);
      send_word(MODE_ADD, 2, 33'sd12345, 0, 0);
      send_word(MODE_DRAW, 0, 0, 2, 32'h8000_0000);
      send_word(MODE_DRAW, 0, 0, 63, 32'hFFFF_FFFF);
      write_entry_count(4);
      send_word(MODE_SET, 10, 33'sd999, 0, 0);
      send_word(MODE_DRAW, 0, 0, 63, 32'hC000_0000);
      send_word(MODE_DRAW, 0, 0, 1, 32'h0000_0001);
      write_entry_count(0);
      send_word(MODE_DRAW, 0, 0, 40, 32'h7FFF_FFFF);
      write_entry_count(127);
      send_word(MODE_DRAW, 0, 0, 63, 32'h0);
      send_word(MODE_DRAW, 0, 0, 10, 32'hFFFF_0000);
   endtask

   task automatic test_random_bursts(int count);
      int n;
      int stop_at;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         n = active_entries();
         repeat ($urandom_range(4, 1)) begin
            if ($urandom_range(19) == 0)
               send_word(MODE_NOP, $urandom_range(63), pick_amount(), 0, $urandom());
            else
               send_word($urandom_range(1) ? MODE_SET : MODE_ADD,
                  $urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(n - 1),
                  pick_amount(), 0, 0);
         end
         repeat ($urandom_range(6, 1))
            send_word(MODE_DRAW, $urandom_range(63), pick_amount(),
               $urandom_range(7) == 0 ? $urandom_range(63) : $urandom_range(n - 1),
               $urandom());
      end
   endtask

   task automatic test_backpressure();
      hold_left = 400;
      repeat (40)
         send_word(2'($urandom_range(2)), $urandom_range(63), pick_amount(),
            $urandom_range(63), $urandom());
      wait_idle();
      send_word(MODE_SET, 3, 33'sd50, 0, 0);
      send_word(MODE_DRAW, 0, 0, 3, $urandom());
   endtask

   task automatic test_idle_phases();
      int idle_cfg [4][2] = '{'{0, 0}, '{52, 0}, '{0, 52}, '{19, 19}};
      bit [CNT_W-1:0] counts [4] = '{7'd64, 7'd2, 7'd1, 7'd0};
      for (int p = 0; p < 4; p++) begin
         write_entry_count(p == 3 ? 7'($urandom_range(127)) : counts[p]);
         send_idle_pct = idle_cfg[p][0];
         stall_pct = idle_cfg[p][1];
         test_random_bursts(150);
         wait_idle();
         write_entry_count(7'($urandom_range(64, 1)));
         test_random_bursts(150);
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      foreach (weight_mem[i]) weight_mem[i] = 0;
      weight_sum = 0;
      table_dirty = 1;
      entry_count = N_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_idle_phases();
      wait_idle();
      repeat (20) @(posedge clock);
      $display("sent %0d words, checked %0d draws over several entry counts and idle mixes",
         words_sent, draws_checked);
      if (mismatches == 0 && pending_samples.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL");
      end
      $finish;
   end

endmodule
